// File: src/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared register indexes, reset values and the item type that travels from
// the transform front end through the queue to the divide and merge back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pbm_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_COEF_A   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_COEF_B   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COEF_C   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COEF_D   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y = 3'd5;

  localparam logic [31:0] COEF_ONE       = 32'h0001_0000;
  localparam logic [31:0] BOX_LOW_RESET  = 32'h7FFF_FFFF;
  localparam logic [31:0] BOX_HIGH_RESET = 32'h8000_0000;

  localparam logic CMD_CLEAR = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        cmd;
    logic [63:0] num_x;
    logic [63:0] num_y;
  } item_t;

endpackage

`default_nettype wire

// File: src/pbm_front.sv
// ----------------------------------------------------------------------------
// pbm_front
// Holds the configuration registers, accepts input beats and computes the two
// 64-bit numerators (transform, scale by 25, origin add) in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [pbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         cmd_i,
  input  wire logic signed [31:0]           point_x_i,
  input  wire logic signed [31:0]           point_y_i,
  output logic                              push_o,
  output pbm_pkg::item_t                    item_o,
  input  wire logic                         full_i
);

  logic signed [31:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic signed [31:0] origin_x_q, origin_y_q;

  logic [3:0] vld_q;
  logic       en;

  logic               cmd0_q, cmd1_q, cmd2_q, cmd3_q;
  logic signed [31:0] px_q, py_q;
  logic signed [63:0] pax_q, pcy_q, pbx_q, pdy_q;
  logic signed [63:0] sx_q, sy_q;
  logic [63:0]        numx_q, numy_q;

  logic [63:0] orgx_ext, orgy_ext;

  assign en         = !(vld_q[3] && full_i);
  assign in_stall_o = !en;
  assign push_o     = vld_q[3] && !full_i;

  assign orgx_ext = {{32{origin_x_q[31]}}, origin_x_q};
  assign orgy_ext = {{32{origin_y_q[31]}}, origin_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q   <= pbm_pkg::COEF_ONE;
      coef_b_q   <= '0;
      coef_c_q   <= '0;
      coef_d_q   <= pbm_pkg::COEF_ONE;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pbm_pkg::CFG_COEF_A:   coef_a_q   <= cfg_data_i;
        pbm_pkg::CFG_COEF_B:   coef_b_q   <= cfg_data_i;
        pbm_pkg::CFG_COEF_C:   coef_c_q   <= cfg_data_i;
        pbm_pkg::CFG_COEF_D:   coef_d_q   <= cfg_data_i;
        pbm_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        pbm_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd0_q <= cmd_i;
      px_q   <= point_x_i;
      py_q   <= point_y_i;

      cmd1_q <= cmd0_q;
      pax_q  <= coef_a_q * px_q;
      pcy_q  <= coef_c_q * py_q;
      pbx_q  <= coef_b_q * px_q;
      pdy_q  <= coef_d_q * py_q;

      cmd2_q <= cmd1_q;
      sx_q   <= pax_q + pcy_q;
      sy_q   <= pbx_q + pdy_q;

      cmd3_q <= cmd2_q;
      numx_q <= (sx_q << 4) + (sx_q << 3) + sx_q + (orgx_ext << 12);
      numy_q <= (sy_q << 4) + (sy_q << 3) + sy_q + (orgy_ext << 12);
    end
  end

  assign item_o.cmd   = cmd3_q;
  assign item_o.num_x = numx_q;
  assign item_o.num_y = numy_q;

endmodule

`default_nettype wire

// File: src/pbm_queue.sv
// ----------------------------------------------------------------------------
// pbm_queue
// Small first-in first-out buffer that decouples the front end from the
// divide and merge back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_queue #(
  parameter int unsigned DEPTH = pbm_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pbm_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output pbm_pkg::item_t      item_o,
  output logic                avail_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  pbm_pkg::item_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign avail_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: src/pbm_back.sv
// ----------------------------------------------------------------------------
// pbm_back
// Floor and ceiling divide of both numerators by 1000 << 12, done as a shift
// and a four-stage long division by 1000, then the box merge and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pbm_pkg::item_t     item_i,
  input  wire logic               avail_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      out_left_o,
  output logic signed [31:0]      out_bottom_o,
  output logic signed [31:0]      out_right_o,
  output logic signed [31:0]      out_top_o,
  output logic                    is_empty_o
);

  localparam int unsigned ChunkW    = 13;
  localparam int unsigned NumChunks = 4;
  localparam int unsigned UW        = ChunkW * NumChunks;
  localparam int unsigned RemW      = 10;
  localparam int unsigned StepW     = RemW + ChunkW;
  localparam int unsigned RecipW    = 24;
  localparam int unsigned ProdW     = StepW + RecipW;
  localparam int unsigned RecipSh   = 33;
  localparam logic [RecipW-1:0] Recip   = 24'd8589935;
  localparam logic [RemW-1:0]   Divisor = 10'd1000;
  localparam logic [RemW-1:0]   RemMax  = 10'd999;

  typedef struct packed {
    logic            neg;
    logic            r12nz;
    logic [UW-1:0]   u;
    logic [RemW-1:0] rem;
    logic [UW-1:0]   q;
  } lane_t;

  typedef struct packed {
    logic  cmd;
    lane_t lx;
    lane_t ly;
  } stage_t;

  function automatic lane_t lane_init(input logic [63:0] num);
    lane_t r;
    r.neg   = num[63];
    r.r12nz = |num[11:0];
    r.u     = num[63] ? ~num[63:12] : num[63:12];
    r.rem   = '0;
    r.q     = '0;
    return r;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input int unsigned k);
    lane_t             r;
    logic [ChunkW-1:0] chunk;
    logic [StepW-1:0]  v;
    logic [ProdW-1:0]  prod;
    logic [ChunkW-1:0] qd;
    logic [StepW-1:0]  rem_full;
    chunk    = l.u[UW-1-ChunkW*k -: ChunkW];
    v        = {l.rem, chunk};
    prod     = ProdW'(v) * ProdW'(Recip);
    qd       = prod[RecipSh +: ChunkW];
    rem_full = v - StepW'(qd) * StepW'(Divisor);
    r        = l;
    r.rem    = rem_full[RemW-1:0];
    r.q      = {l.q[UW-ChunkW-1:0], qd};
    return r;
  endfunction

  function automatic logic [31:0] lane_lo(input lane_t l);
    return l.neg ? ~l.q[31:0] : l.q[31:0];
  endfunction

  function automatic logic [31:0] lane_hi(input lane_t l);
    logic nz;
    nz = l.r12nz || (l.neg ? (l.rem != RemMax) : (l.rem != '0));
    return lane_lo(l) + {31'b0, nz};
  endfunction

  stage_t             st_q [0:NumChunks];
  stage_t             st_d [0:NumChunks];
  logic [NumChunks:0] vld_q;
  logic               en;

  logic [31:0] box_left_q, box_bottom_q, box_right_q, box_top_q;
  logic [31:0] box_left_d, box_bottom_d, box_right_d, box_top_d;
  logic [31:0] lo_x, lo_y, hi_x, hi_y;
  logic        out_valid_q;
  logic        merge;

  assign en    = !(vld_q[NumChunks] && out_valid_q && out_stall_i);
  assign pop_o = avail_i && en;
  assign merge = en && vld_q[NumChunks];

  always_comb begin
    st_d[0].cmd = item_i.cmd;
    st_d[0].lx  = lane_init(item_i.num_x);
    st_d[0].ly  = lane_init(item_i.num_y);
    for (int unsigned k = 1; k <= NumChunks; k++) begin
      st_d[k].cmd = st_q[k-1].cmd;
      st_d[k].lx  = lane_step(st_q[k-1].lx, k - 1);
      st_d[k].ly  = lane_step(st_q[k-1].ly, k - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumChunks-1:0], avail_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned k = 0; k <= NumChunks; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign lo_x = lane_lo(st_q[NumChunks].lx);
  assign lo_y = lane_lo(st_q[NumChunks].ly);
  assign hi_x = lane_hi(st_q[NumChunks].lx);
  assign hi_y = lane_hi(st_q[NumChunks].ly);

  always_comb begin
    if (st_q[NumChunks].cmd == pbm_pkg::CMD_CLEAR) begin
      box_left_d   = pbm_pkg::BOX_LOW_RESET;
      box_bottom_d = pbm_pkg::BOX_LOW_RESET;
      box_right_d  = pbm_pkg::BOX_HIGH_RESET;
      box_top_d    = pbm_pkg::BOX_HIGH_RESET;
    end else begin
      box_left_d   = ($signed(lo_x) < $signed(box_left_q))   ? lo_x : box_left_q;
      box_bottom_d = ($signed(lo_y) < $signed(box_bottom_q)) ? lo_y : box_bottom_q;
      box_right_d  = ($signed(hi_x) > $signed(box_right_q))  ? hi_x : box_right_q;
      box_top_d    = ($signed(hi_y) > $signed(box_top_q))    ? hi_y : box_top_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q   <= pbm_pkg::BOX_LOW_RESET;
      box_bottom_q <= pbm_pkg::BOX_LOW_RESET;
      box_right_q  <= pbm_pkg::BOX_HIGH_RESET;
      box_top_q    <= pbm_pkg::BOX_HIGH_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (merge) begin
        box_left_q   <= box_left_d;
        box_bottom_q <= box_bottom_d;
        box_right_q  <= box_right_d;
        box_top_q    <= box_top_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge) begin
      out_left_o   <= box_left_d;
      out_bottom_o <= box_bottom_d;
      out_right_o  <= box_right_d;
      out_top_o    <= box_top_d;
      is_empty_o   <= ($signed(box_left_d) > $signed(box_right_d)) ||
                      ($signed(box_bottom_d) > $signed(box_top_d));
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/page_bbox_point_merge.sv
// ----------------------------------------------------------------------------
// page_bbox_point_merge
// Transforms points into page space and accumulates their bounding box in
// whole points; a clear beat empties the box.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Beat
// in       input      in_valid_i / in_stall_o   cmd, point_x, point_y
// out      output     out_valid_o / out_stall_i box corners, is_empty
// cfg      input      cfg_valid_i / cfg_ready_o register index, write data
//
// One beat is accepted per cycle when nothing stalls; each result passes
// through the multiply and sum stages of the front end, the queue and the
// four-stage divide by 1000.
// Reset gives the identity transform, a zero origin and an empty box.
// The front stalls its input only when its last stage holds a beat and the
// queue is full; the back stalls only while the result register is held.
// ----------------------------------------------------------------------------
`default_nettype none

module page_bbox_point_merge #(
  parameter int unsigned QUEUE_DEPTH = pbm_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [pbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         cmd_i,
  input  wire logic signed [31:0]           point_x_i,
  input  wire logic signed [31:0]           point_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [31:0]                out_left_o,
  output logic signed [31:0]                out_bottom_o,
  output logic signed [31:0]                out_right_o,
  output logic signed [31:0]                out_top_o,
  output logic                              is_empty_o
);

  logic           push, full, pop, avail;
  pbm_pkg::item_t front_item, queue_item;

  assign cfg_ready_o = 1'b1;

  pbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .push_o      (push),
    .item_o      (front_item),
    .full_i      (full)
  );

  pbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .avail_o (avail)
  );

  pbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (queue_item),
    .avail_i      (avail),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_left_o   (out_left_o),
    .out_bottom_o (out_bottom_o),
    .out_right_o  (out_right_o),
    .out_top_o    (out_top_o),
    .is_empty_o   (is_empty_o)
  );

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives page_bbox_point_merge with a short table of directed beats and then
// with random merge and clear beats under several transform settings. Each
// accepted input beat is run through a local model of the transform, the
// floor and ceil divide and the box merge, and every output beat is checked
// field by field against the oldest pending box. Both channels idle at
// random, and one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------

module testbench;

  localparam logic              CMD_MERGE   = 1'b0;
  localparam logic signed [31:0] S32_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;
  localparam bit [63:0]         PAGE_DIV    = 64'd1000 << 12;
  localparam int                HOLD_CYCLES = 300;
  localparam int                DRAIN_LIMIT = 4000;
  localparam int                TAIL_CYCLES = 24;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] bottom;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic               empty;
  } box_t;

  localparam box_t EMPTY_BOX = '{pbm_pkg::BOX_LOW_RESET, pbm_pkg::BOX_LOW_RESET,
                                 pbm_pkg::BOX_HIGH_RESET, pbm_pkg::BOX_HIGH_RESET,
                                 1'b1};

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 typed;
    box_t               box;
  } directed_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [pbm_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [31:0]                  cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         cmd_i;
  logic signed [31:0]           point_x_i;
  logic signed [31:0]           point_y_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [31:0]           out_left_o;
  logic signed [31:0]           out_bottom_o;
  logic signed [31:0]           out_right_o;
  logic signed [31:0]           out_top_o;
  logic                         is_empty_o;

  logic signed [31:0]  model_regs [6];
  box_t                model_box;
  box_t                pending_boxes [$];
  int                  error_count = 0;
  int                  send_idle_pct = 31;
  int                  recv_idle_pct = 55;
  bit                  hold_armed = 1'b0;
  bit                  hold_served = 1'b0;

  directed_row_t directed_rows [12] = '{
    '{CMD_MERGE, 32'sd1000, -32'sd1000, 1'b1, '{32'sd400, -32'sd400, 32'sd400, -32'sd400, 1'b0}},
    '{pbm_pkg::CMD_CLEAR, S32_MIN, -32'sd1, 1'b1, EMPTY_BOX},
    '{CMD_MERGE, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0}},
    '{CMD_MERGE, 32'sd1000, 32'sd1000, 1'b1, '{32'sd0, 32'sd0, 32'sd400, 32'sd400, 1'b0}},
    '{CMD_MERGE, -32'sd1000, -32'sd1000, 1'b1,
      '{-32'sd400, -32'sd400, 32'sd400, 32'sd400, 1'b0}},
    '{CMD_MERGE, 32'sd1, -32'sd1, 1'b1, '{-32'sd400, -32'sd400, 32'sd400, 32'sd400, 1'b0}},
    '{CMD_MERGE, S32_MAX, S32_MIN, 1'b0, '0},
    '{CMD_MERGE, S32_MIN, S32_MAX, 1'b0, '0},
    '{pbm_pkg::CMD_CLEAR, -32'sd1, S32_MAX, 1'b1, EMPTY_BOX},
    '{CMD_MERGE, S32_MAX, S32_MAX, 1'b0, '0},
    '{CMD_MERGE, S32_MIN, S32_MIN, 1'b0, '0},
    '{CMD_MERGE, -32'sd1, 32'sd1, 1'b0, '0}
  };

  page_bbox_point_merge dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_left_o   (out_left_o),
    .out_bottom_o (out_bottom_o),
    .out_right_o  (out_right_o),
    .out_top_o    (out_top_o),
    .is_empty_o   (is_empty_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint lane_sum(logic signed [31:0] k1, logic signed [31:0] v1,
                                      logic signed [31:0] k2, logic signed [31:0] v2,
                                      logic signed [31:0] org);
    longint p1;
    longint p2;
    p1 = longint'(k1) * longint'(v1);
    p2 = longint'(k2) * longint'(v2);
    return (p1 + p2) * 64'sd25 + (longint'(org) <<< 12);
  endfunction

  function automatic void floor_ceil(input longint num, output logic signed [31:0] lo,
                                     output logic signed [31:0] hi);
    bit [63:0] mag;
    bit [63:0] quo;
    bit [63:0] rem;
    mag = num;
    if (num < 0) mag = -mag;
    quo = mag / PAGE_DIV;
    rem = mag % PAGE_DIV;
    if (num < 0) quo = -quo - ((rem != 0) ? 64'd1 : 64'd0);
    lo = quo[31:0];
    quo = quo + ((rem != 0) ? 64'd1 : 64'd0);
    hi = quo[31:0];
  endfunction

  function automatic box_t merge_point(logic cmd, logic signed [31:0] x,
                                       logic signed [31:0] y);
    logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
    if (cmd == pbm_pkg::CMD_CLEAR) begin
      model_box = EMPTY_BOX;
    end else begin
      floor_ceil(lane_sum(model_regs[pbm_pkg::CFG_COEF_A], x,
                          model_regs[pbm_pkg::CFG_COEF_C], y,
                          model_regs[pbm_pkg::CFG_ORIGIN_X]), lo_x, hi_x);
      floor_ceil(lane_sum(model_regs[pbm_pkg::CFG_COEF_B], x,
                          model_regs[pbm_pkg::CFG_COEF_D], y,
                          model_regs[pbm_pkg::CFG_ORIGIN_Y]), lo_y, hi_y);
      if (model_box.left > lo_x) model_box.left = lo_x;
      if (model_box.bottom > lo_y) model_box.bottom = lo_y;
      if (model_box.right < hi_x) model_box.right = hi_x;
      if (model_box.top < hi_y) model_box.top = hi_y;
    end
    model_box.empty = (model_box.left > model_box.right) ||
                      (model_box.bottom > model_box.top);
    return model_box;
  endfunction

  function automatic logic signed [31:0] pick_word(int unsigned span, int unsigned wild_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < wild_pct / 2) begin
      case ($urandom_range(3))
        0: return S32_MIN;
        1: return S32_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end else if (roll < wild_pct) begin
      return $urandom();
    end
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (want !== got)
      report_error($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  always @(posedge clk_i) begin
    box_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_boxes.size() == 0) begin
        report_error("output beat with no box pending");
      end else begin
        want = pending_boxes.pop_front();
        compare_field("out_left", want.left, out_left_o);
        compare_field("out_bottom", want.bottom, out_bottom_o);
        compare_field("out_right", want.right, out_right_o);
        compare_field("out_top", want.top, out_top_o);
        compare_field("is_empty", 32'(want.empty), 32'(is_empty_o));
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_served) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_served = 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [pbm_pkg::CfgIdxW-1:0] idx, logic signed [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_regs[idx] = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_transform(logic signed [31:0] a, logic signed [31:0] b,
                                 logic signed [31:0] c, logic signed [31:0] d,
                                 logic signed [31:0] ox, logic signed [31:0] oy);
    write_reg(pbm_pkg::CFG_COEF_A, a);
    write_reg(pbm_pkg::CFG_COEF_B, b);
    write_reg(pbm_pkg::CFG_COEF_C, c);
    write_reg(pbm_pkg::CFG_COEF_D, d);
    write_reg(pbm_pkg::CFG_ORIGIN_X, ox);
    write_reg(pbm_pkg::CFG_ORIGIN_Y, oy);
  endtask

  task automatic send_beat(logic cmd, logic signed [31:0] x, logic signed [31:0] y,
                           bit typed, box_t typed_box);
    box_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    point_x_i  <= x;
    point_y_i  <= y;
    do @(posedge clk_i); while (in_stall_o);
    predicted = merge_point(cmd, x, y);
    pending_boxes.push_back(typed ? typed_box : predicted);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_boxes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  initial begin
    logic cmd;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pbm_pkg::CFG_COEF_A;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_MERGE;
    point_x_i   = '0;
    point_y_i   = '0;
    model_regs  = '{pbm_pkg::COEF_ONE, 32'sd0, 32'sd0, pbm_pkg::COEF_ONE, 32'sd0, 32'sd0};
    model_box   = EMPTY_BOX;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].typed, directed_rows[i].box);
    drain_results();

    write_transform(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MIN);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y, 1'b0, '0);
    drain_results();

    for (int profile = 0; profile < 3; profile++) begin
      send_idle_pct = (profile == 0) ? 31 : (profile == 1) ? 55 : 0;
      recv_idle_pct = (profile == 0) ? 55 : (profile == 1) ? 31 : 0;
      for (int setting = 0; setting < 4; setting++) begin
        write_transform(pick_word(32'h2_0000, 40), pick_word(32'h2_0000, 40),
                        pick_word(32'h2_0000, 40), pick_word(32'h2_0000, 40),
                        pick_word(1_000_000, 40), pick_word(1_000_000, 40));
        if (profile == 2 && setting == 0) hold_armed = 1'b1;
        for (int n = 0; n < 120; n++) begin
          cmd = ($urandom_range(99) < 6) ? pbm_pkg::CMD_CLEAR : CMD_MERGE;
          send_beat(cmd, pick_word(20000, 20), pick_word(20000, 20), 1'b0, '0);
        end
        drain_results();
      end
    end

    write_transform(S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MAX);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y, 1'b0, '0);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_boxes.size() != 0)
      report_error($sformatf("%0d boxes never arrived", pending_boxes.size()));

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
